### sv/wssa_pkg.sv
// Shared types, register codes and constants of the water sensor smoothing and alarm block.
package wssa_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CAL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PH_CAL    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PH_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PH_HIGH   = 3'd5;
    localparam int unsigned CFG_DATA_W = 14;

    // Register reset values
    localparam logic signed [11:0] TEMP_CAL_RST  = 12'sd0;
    localparam logic [13:0]        TEMP_LOW_RST  = 14'd6144;
    localparam logic [13:0]        TEMP_HIGH_RST = 14'd7168;
    localparam logic signed [12:0] PH_CAL_RST    = 13'sd0;
    localparam logic [13:0]        PH_LOW_RST    = 14'd6656;
    localparam logic [13:0]        PH_HIGH_RST   = 14'd7680;

    // Special temperature sensor codes, 1/16 degC
    localparam logic signed [11:0] TEMP_ERROR_CODE = -12'sd2032;
    localparam logic signed [11:0] TEMP_POWER_ON   = 12'sd1360;

    // State reset values
    localparam logic signed [15:0] TEMP_FILTER_RST = 16'sd0;
    localparam logic signed [15:0] PH_FILTER_RST   = 16'sd7168;
    localparam logic signed [15:0] TEMP_MIN_RST    = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_MAX_RST    = 16'sh8000;

    // Hysteresis margins, 0.2 degC and 0.2 pH
    localparam logic signed [17:0] TEMP_HYST = 18'sd51;
    localparam logic signed [17:0] PH_HYST   = 18'sd205;

    // Band codes
    localparam logic [1:0] BAND_OK   = 2'd0;
    localparam logic [1:0] BAND_LOW  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam int unsigned WORK_DEPTH = 4;

    typedef struct packed {
        logic              temp_present;
        logic signed [11:0] temp_sample;
        logic              ph_present;
        logic [11:0]       ph_sample;
        logic              water_ok;
        logic              check_alarms;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] smoothed_temp;
        logic signed [15:0] smoothed_ph;
        logic signed [15:0] lowest_temp;
        logic signed [15:0] highest_temp;
        logic               sensor_ok;
        logic [1:0]         temp_status;
        logic [1:0]         ph_status;
        logic               temp_event;
        logic               ph_event;
        logic               water_event;
    } t_out_item;

    typedef struct packed {
        logic signed [11:0] temp_cal;
        logic [13:0]        temp_low;
        logic [13:0]        temp_high;
        logic signed [12:0] ph_cal;
        logic [13:0]        ph_low;
        logic [13:0]        ph_high;
    } t_cfg;

    // What a temperature field does to the temperature state
    typedef enum logic [1:0] {
        TK_NONE,    // no sample: nothing changes
        TK_LOST,    // error code: sensor lost
        TK_KEEP,    // power-on code: connected, filter kept
        TK_SAMPLE   // real sample: connected, filter updated
    } t_temp_kind;

    typedef struct packed {
        t_temp_kind         temp_kind;
        logic signed [15:0] temp_x;
        logic               ph_valid;
        logic signed [15:0] ph_y;
        logic               water_ok;
        logic               check;
    } t_work;

endpackage

### sv/wssa_front.sv
// Front end: classifies the temperature field and scales both samples.
module wssa_front (
    input  wssa_pkg::t_in_item i_item,
    input  wssa_pkg::t_cfg     i_cfg,
    output wssa_pkg::t_work    o_work
);
    import wssa_pkg::*;

    // round(raw * 19712 / 6825) = floor((raw * 39424 + 6825) / 13650)
    localparam int unsigned PhShift = 42;
    localparam logic [28:0] PhRecip = 29'(((64'd1 << PhShift) + 64'd13649) / 64'd13650);

    logic signed [16:0] temp_sum;
    logic signed [15:0] temp_x;
    logic [27:0]        ph_num;
    logic [56:0]        ph_prod;
    logic [13:0]        ph_scaled;
    t_temp_kind         kind;

    always_comb begin
        temp_sum = (17'(i_item.temp_sample) <<< 4) + 17'(i_cfg.temp_cal);
        if (temp_sum > 17'sd32767) begin
            temp_x = 16'sh7FFF;
        end else if (temp_sum < -17'sd32768) begin
            temp_x = 16'sh8000;
        end else begin
            temp_x = temp_sum[15:0];
        end

        if (!i_item.temp_present) begin
            kind = TK_NONE;
        end else if (i_item.temp_sample == TEMP_ERROR_CODE) begin
            kind = TK_LOST;
        end else if (i_item.temp_sample == TEMP_POWER_ON) begin
            kind = TK_KEEP;
        end else begin
            kind = TK_SAMPLE;
        end
    end

    // exact for every numerator below 2^28
    assign ph_num    = 28'(i_item.ph_sample) * 28'd39424 + 28'd6825;
    assign ph_prod   = 57'(ph_num) * 57'(PhRecip);
    assign ph_scaled = ph_prod[55:42];

    always_comb begin
        o_work.temp_kind = kind;
        o_work.temp_x    = temp_x;
        o_work.ph_valid  = i_item.ph_present;
        // scaled reading plus a 13-bit offset always fits 16 bits
        o_work.ph_y      = $signed({2'b00, ph_scaled}) + 16'(i_cfg.ph_cal);
        o_work.water_ok  = i_item.water_ok;
        o_work.check     = i_item.check_alarms;
    end

endmodule

### sv/wssa_fifo.sv
// Short work queue between the front end and the back end.
module wssa_fifo #(
    parameter int unsigned Depth = wssa_pkg::WORK_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wssa_pkg::t_work i_data,
    output logic            o_ready,
    output logic            o_valid,
    output wssa_pkg::t_work o_data,
    input  logic            i_pop
);
    import wssa_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_work            r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]  r_count;

    assign o_ready = (r_count != CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("work queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into a full work queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - CntW'(1)))
        else $error("pop without push did not drain one entry");

endmodule

### sv/wssa_back.sv
// Back end: filter update stage, then min/max, hysteresis bands and the output register.
module wssa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wssa_pkg::t_cfg    i_cfg,
    input  logic              i_work_valid,
    input  wssa_pkg::t_work   i_work,
    output logic              o_pop,
    output logic              o_out_valid,
    output wssa_pkg::t_out_item o_out_item,
    input  logic              i_out_ready
);
    import wssa_pkg::*;

    localparam int unsigned DivShift = 23;
    localparam logic [19:0] Div10Recip = 20'(((64'd1 << DivShift) + 64'd9) / 64'd10);
    localparam logic signed [20:0] Div10Bias = 21'sd327685;   // 10 * 32768 + 5

    // floor((s + 5) / 10); s is a weighted sum of two 16-bit values
    function automatic logic signed [15:0] div10_round(input logic signed [19:0] s);
        logic signed [20:0] t;
        logic [19:0]        u;
        logic [39:0]        p;
        t = 21'(s) + Div10Bias;
        u = t[19:0];
        p = 40'(u) * 40'(Div10Recip);
        return {~p[38], p[37:23]};
    endfunction

    typedef struct packed {
        logic signed [15:0] temp_filter;
        logic signed [15:0] ph_filter;
        logic               sensor;
        logic               temp_upd;
        logic               water_ok;
        logic               check;
    } t_mid;

    logic               en;
    // stage A state
    logic signed [15:0] r_temp_filter, r_ph_filter;
    logic               r_temp_seen, r_ph_seen, r_sensor;
    logic               r_a_valid;
    t_mid               r_mid;
    // stage B state
    logic signed [15:0] r_temp_min, r_temp_max;
    logic [1:0]         r_last_tband, r_last_pband;
    logic               r_last_water;
    t_out_item          r_out;
    logic               r_out_valid;

    logic signed [19:0] temp_sum, ph_sum;
    t_mid               n_mid;
    logic signed [15:0] n_temp_min, n_temp_max;
    logic [1:0]         n_tband, n_pband;
    logic signed [17:0] f_t, f_p, t_lo, t_hi, p_lo, p_hi;

    assign en          = !r_out_valid || i_out_ready;
    assign o_pop       = en && i_work_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---- stage A: filter update
    assign temp_sum = 20'sd7 * 20'(r_temp_filter) + 20'sd3 * 20'(i_work.temp_x);
    assign ph_sum   = 20'sd8 * 20'(r_ph_filter) + 20'sd2 * 20'(i_work.ph_y);

    always_comb begin
        n_mid.temp_filter = r_temp_filter;
        n_mid.ph_filter   = r_ph_filter;
        n_mid.sensor      = r_sensor;
        n_mid.temp_upd    = 1'b0;
        n_mid.water_ok    = i_work.water_ok;
        n_mid.check       = i_work.check;
        unique case (i_work.temp_kind)
            TK_NONE: ;
            TK_LOST: n_mid.sensor = 1'b0;
            TK_KEEP: n_mid.sensor = 1'b1;
            TK_SAMPLE: begin
                n_mid.sensor      = 1'b1;
                n_mid.temp_upd    = 1'b1;
                n_mid.temp_filter = r_temp_seen ? div10_round(temp_sum) : i_work.temp_x;
            end
            default: ;
        endcase
        if (i_work.ph_valid) begin
            n_mid.ph_filter = r_ph_seen ? div10_round(ph_sum) : i_work.ph_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_filter <= TEMP_FILTER_RST;
            r_ph_filter   <= PH_FILTER_RST;
            r_temp_seen   <= 1'b0;
            r_ph_seen     <= 1'b0;
            r_sensor      <= 1'b0;
            r_a_valid     <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_work_valid;
            if (i_work_valid) begin
                r_temp_filter <= n_mid.temp_filter;
                r_ph_filter   <= n_mid.ph_filter;
                r_sensor      <= n_mid.sensor;
                if (n_mid.temp_upd) begin
                    r_temp_seen <= 1'b1;
                end
                if (i_work.ph_valid) begin
                    r_ph_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mid <= n_mid;
        end
    end

    // ---- stage B: extremes, bands and events
    always_comb begin
        n_temp_min = r_temp_min;
        n_temp_max = r_temp_max;
        if (r_mid.temp_upd && (r_mid.temp_filter < r_temp_min)) begin
            n_temp_min = r_mid.temp_filter;
        end
        if (r_mid.temp_upd && (r_mid.temp_filter > r_temp_max)) begin
            n_temp_max = r_mid.temp_filter;
        end

        f_t  = 18'(r_mid.temp_filter);
        f_p  = 18'(r_mid.ph_filter);
        t_lo = $signed({4'b0000, i_cfg.temp_low});
        t_hi = $signed({4'b0000, i_cfg.temp_high});
        p_lo = $signed({4'b0000, i_cfg.ph_low});
        p_hi = $signed({4'b0000, i_cfg.ph_high});

        // a lost sensor reads as ok
        n_tband = BAND_OK;
        if (r_mid.sensor) begin
            unique case (r_last_tband)
                BAND_LOW:  n_tband = (f_t >= t_lo + TEMP_HYST) ? BAND_OK : BAND_LOW;
                BAND_HIGH: n_tband = (f_t <= t_hi - TEMP_HYST) ? BAND_OK : BAND_HIGH;
                default: begin
                    if (f_t <= t_lo - TEMP_HYST) begin
                        n_tband = BAND_LOW;
                    end else if (f_t >= t_hi + TEMP_HYST) begin
                        n_tband = BAND_HIGH;
                    end
                end
            endcase
        end

        // from ok, too high wins when both tests hold
        n_pband = r_last_pband;
        unique case (r_last_pband)
            BAND_LOW:  if (f_p >= p_lo + PH_HYST) n_pband = BAND_OK;
            BAND_HIGH: if (f_p <= p_hi - PH_HYST) n_pband = BAND_OK;
            default: begin
                if (f_p >= p_hi + PH_HYST) begin
                    n_pband = BAND_HIGH;
                end else if (f_p <= p_lo - PH_HYST) begin
                    n_pband = BAND_LOW;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_min   <= TEMP_MIN_RST;
            r_temp_max   <= TEMP_MAX_RST;
            r_last_tband <= BAND_OK;
            r_last_pband <= BAND_OK;
            r_last_water <= 1'b1;
            r_out_valid  <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_a_valid;
            if (r_a_valid) begin
                r_temp_min <= n_temp_min;
                r_temp_max <= n_temp_max;
                if (r_mid.check) begin
                    r_last_tband <= n_tband;
                    r_last_pband <= n_pband;
                    r_last_water <= r_mid.water_ok;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_a_valid) begin
            r_out.smoothed_temp <= r_mid.temp_filter;
            r_out.smoothed_ph   <= r_mid.ph_filter;
            r_out.lowest_temp   <= n_temp_min;
            r_out.highest_temp  <= n_temp_max;
            r_out.sensor_ok     <= r_mid.sensor;
            r_out.temp_status   <= r_mid.check ? n_tband : r_last_tband;
            r_out.ph_status     <= r_mid.check ? n_pband : r_last_pband;
            r_out.temp_event    <= r_mid.check && (n_tband != r_last_tband);
            r_out.ph_event      <= r_mid.check && (n_pband != r_last_pband);
            r_out.water_event   <= r_mid.check && (r_mid.water_ok != r_last_water);
        end
    end

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_temp_min) && $stable(r_last_tband)
                                            && $stable(r_temp_filter)))
        else $error("back end state moved while the output was stalled");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_temp_min != TEMP_MIN_RST) |-> (r_temp_min <= r_temp_max))
        else $error("running minimum above running maximum");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && en) |=> r_out_valid)
        else $error("item in filter stage did not reach the output register");

endmodule

### sv/water_sensor_smoothing_alarm_core.sv
// Top level of the water sensor smoothing and alarm block.
// Path: an accepted item is written into the queue, then registered in the filter stage
// and then in the output register; items wait in place while the output stalls.
// Throughput: one item per cycle unless the output stalls, set by the filter update
// loop (weighted sum and divide-by-ten reciprocal multiply in the filter stage).
// Reset: synchronous, active low; registers, filters, extremes and bands take their
// reset values at once, no clearing pass. Configuration writes are registered.
module water_sensor_smoothing_alarm_core #(
    parameter int unsigned WorkDepth = wssa_pkg::WORK_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wssa_pkg::t_in_item                  i_in_item,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wssa_pkg::t_out_item                 o_out_item,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wssa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [wssa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import wssa_pkg::*;

    t_cfg   r_cfg;
    t_work  front_work;
    t_work  queue_work;
    logic   push;
    logic   queue_ready;
    logic   queue_valid;
    logic   pop;

    // Register file: always ready, writes past the last index are dropped.
    // Each register keeps only its low bits.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_cal  <= TEMP_CAL_RST;
            r_cfg.temp_low  <= TEMP_LOW_RST;
            r_cfg.temp_high <= TEMP_HIGH_RST;
            r_cfg.ph_cal    <= PH_CAL_RST;
            r_cfg.ph_low    <= PH_LOW_RST;
            r_cfg.ph_high   <= PH_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TEMP_CAL:  r_cfg.temp_cal  <= i_cfg_data[11:0];
                REG_TEMP_LOW:  r_cfg.temp_low  <= i_cfg_data[13:0];
                REG_TEMP_HIGH: r_cfg.temp_high <= i_cfg_data[13:0];
                REG_PH_CAL:    r_cfg.ph_cal    <= i_cfg_data[12:0];
                REG_PH_LOW:    r_cfg.ph_low    <= i_cfg_data[13:0];
                REG_PH_HIGH:   r_cfg.ph_high   <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Front end: classify the temperature code, apply offsets, scale the pH reading.
    wssa_front u_front (
        .i_item (i_in_item),
        .i_cfg  (r_cfg),
        .o_work (front_work)
    );

    // Input side stalls only when the queue is full.
    assign o_in_ready = queue_ready;
    assign push       = i_in_valid && queue_ready;

    wssa_fifo #(
        .Depth (WorkDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_work),
        .i_pop   (pop)
    );

    // Back end: filters, extremes, hysteresis bands and the result register.
    wssa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (queue_valid),
        .i_work       (queue_work),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_ready  (i_out_ready)
    );

endmodule
